@@ rtl/mssb_pkg.sv @@
// shared codes, field widths and control types for the multi-stack shared buffer
package mssb_pkg;

  localparam int CMD_W  = 2;
  localparam int IDX_W  = 3;
  localparam int STAT_W = 2;

  // command codes (the unused code decodes as a peek)
  localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd2;
  localparam logic [STAT_W-1:0] STAT_BAD_INDEX = 2'd3;

  // free list request from the sequencer
  typedef struct packed {
    logic take;  // push pulls the head entry off the free list
    logic give;  // pop returns an entry to the front
  } free_cmd_t;

endpackage

@@ rtl/multi_stack_shared_buffer.sv @@
// top level: several lifo stacks linked through one shared value and link store
//
//  channel  | dir | beat fields (tdata, lowest bit first)
//  ---------+-----+----------------------------------------------------------
//  s_axis   | in  | command[1:0], stack_index[4:2], push_value[VW+4:5], zero pad
//  m_axis   | out | read_value[VW-1:0], status[VW+1:VW], now_empty[VW+2], zero pad
//
//  each beat is accepted, which issues the link and value ram reads, then
//  executed, which uses the registered read data and writes back links,
//  values, heads and the free list head; a result held by a stalled m_axis
//  keeps the block in execute until the slot drains
//  reset clears heads, free head, fill mark and valids; the link store
//  needs no clearing pass since entries above the fill mark are implied
module multi_stack_shared_buffer #(
  parameter int CAPACITY    = 1024,
  parameter int NUM_STACKS  = 5,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         s_axis_tvalid,
  output logic                                         s_axis_tready,
  // command, stack_index, push_value, zero pad
  input  logic [((VALUE_WIDTH+mssb_pkg::CMD_W+mssb_pkg::IDX_W+7)/8)*8-1:0] s_axis_tdata,
  output logic                                         m_axis_tvalid,
  input  logic                                         m_axis_tready,
  // read_value, status, now_empty, zero pad
  output logic [((VALUE_WIDTH+mssb_pkg::STAT_W+1+7)/8)*8-1:0] m_axis_tdata
);
  import mssb_pkg::*;

  localparam int VW    = VALUE_WIDTH;
  localparam int OUT_W = ((VW + STAT_W + 1 + 7) / 8) * 8;
  localparam int LW    = $clog2(CAPACITY + 1);   // link code, null is CAPACITY
  localparam int AW    = $clog2(CAPACITY);       // ram address
  // the index field reaches stack seven at most
  localparam int HEADS = (NUM_STACKS < 7) ? NUM_STACKS : 7;
  localparam int HIW   = (HEADS > 1) ? $clog2(HEADS) : 1;
  localparam logic [LW-1:0] LINK_NULL = LW'(CAPACITY);
  localparam logic [VW-1:0] VAL_MIN   = VW'(1) << (VW - 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  // input beat fields
  logic [CMD_W-1:0] in_cmd;
  logic [IDX_W-1:0] in_idx;
  logic [VW-1:0]    in_val;

  assign in_cmd = s_axis_tdata[CMD_W-1:0];
  assign in_idx = s_axis_tdata[CMD_W+IDX_W-1:CMD_W];
  assign in_val = s_axis_tdata[CMD_W+IDX_W+VW-1:CMD_W+IDX_W];

  logic state;
  logic accept;
  logic commit;

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  // execute finishes only when the output slot is free or draining
  assign commit        = (state == S_EXEC) && (!m_axis_tvalid || m_axis_tready);

  // stack heads, one register per addressable stack
  logic [LW-1:0] heads [HEADS];

  logic          in_idx_ok;
  logic [HIW-1:0] in_hsel;
  logic [LW-1:0]  in_head;

  assign in_idx_ok = (in_idx != '0) && (in_idx <= IDX_W'(HEADS));
  assign in_hsel   = HIW'(in_idx - IDX_W'(1));
  assign in_head   = in_idx_ok ? heads[in_hsel] : LINK_NULL;

  // free list
  logic [LW-1:0] free_head;
  free_cmd_t     free_cmd;
  logic [LW-1:0] link_rd;
  logic [VW-1:0] value_rd;

  // read address: free head for push, stack top otherwise; null parks at zero
  logic [LW-1:0] rd_link;
  logic [AW-1:0] rd_addr;

  assign rd_link = (in_cmd == CMD_PUSH) ? free_head : in_head;
  assign rd_addr = (rd_link < LINK_NULL) ? AW'(rd_link) : '0;

  // beat held across the execute cycle
  logic [CMD_W-1:0] cmd_q;
  logic             idx_ok_q;
  logic [HIW-1:0]   hsel_q;
  logic [LW-1:0]    top_q;
  logic [VW-1:0]    val_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else if (accept) begin
      state <= S_EXEC;
    end else if (commit) begin
      state <= S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q    <= in_cmd;
      idx_ok_q <= in_idx_ok;
      hsel_q   <= in_hsel;
      top_q    <= in_head;
      val_q    <= in_val;
    end
  end

  // execute decode
  logic is_push;
  logic is_pop;
  logic top_null;
  logic store_full;
  logic do_push;
  logic do_pop;

  assign is_push    = (cmd_q == CMD_PUSH);
  assign is_pop     = (cmd_q == CMD_POP);
  assign top_null   = (top_q == LINK_NULL);
  assign store_full = (free_head == LINK_NULL);
  assign do_push    = commit && idx_ok_q && is_push && !store_full;
  assign do_pop     = commit && idx_ok_q && is_pop && !top_null;

  assign free_cmd.take = do_push;
  assign free_cmd.give = do_pop;

  // result of the beat in execute
  logic [VW-1:0]     res_value;
  logic [STAT_W-1:0] res_status;
  logic              res_empty;

  always_comb begin
    res_value  = value_rd;
    res_status = STAT_OK;
    res_empty  = 1'b0;
    if (!idx_ok_q) begin
      res_value  = '0;
      res_status = STAT_BAD_INDEX;
    end else if (is_push) begin
      res_value = val_q;
      if (store_full) begin
        res_status = STAT_FULL;
        res_empty  = top_null;
      end
    end else if (top_null) begin
      res_value  = VAL_MIN;
      res_status = STAT_EMPTY;
      res_empty  = 1'b1;
    end else if (is_pop) begin
      res_empty = (link_rd == LINK_NULL);
    end
  end

  // head write-back: pushed slot on push, next link on pop
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HEADS; i++) begin
        heads[i] <= LINK_NULL;
      end
    end else if (do_push) begin
      heads[hsel_q] <= free_head;
    end else if (do_pop) begin
      heads[hsel_q] <= link_rd;
    end
  end

  // link store write: new slot links to old top, popped entry links to free head
  logic          link_we;
  logic [AW-1:0] link_waddr;
  logic [LW-1:0] link_wdata;

  assign link_we    = do_push || do_pop;
  assign link_waddr = do_push ? AW'(free_head) : AW'(top_q);
  assign link_wdata = do_push ? top_q : free_head;

  mssb_ram #(
    .WIDTH (LW),
    .DEPTH (CAPACITY)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (link_rd)
  );

  mssb_ram #(
    .WIDTH (VW),
    .DEPTH (CAPACITY)
  ) u_value_ram (
    .clk   (clk),
    .we    (do_push),
    .waddr (AW'(free_head)),
    .wdata (val_q),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (value_rd)
  );

  mssb_free_list #(
    .CAPACITY (CAPACITY)
  ) u_free_list (
    .clk       (clk),
    .rst       (rst),
    .cmd       (free_cmd),
    .entry     (top_q),
    .link_rd   (link_rd),
    .free_head (free_head)
  );

  // output register
  logic [VW-1:0]     out_value;
  logic [STAT_W-1:0] out_status;
  logic              out_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (commit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_value  <= res_value;
      out_status <= res_status;
      out_empty  <= res_empty;
    end
  end

  assign m_axis_tdata = OUT_W'({out_empty, out_status, out_value});

endmodule

@@ rtl/mssb_ram.sv @@
// generic single-port-write, single-port-read ram with registered read data
module mssb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/mssb_free_list.sv @@
// free list head and fill mark; never-used entries link to their successor
module mssb_free_list #(
  parameter int CAPACITY = 1024
) (
  input  logic                             clk,
  input  logic                             rst,
  input  mssb_pkg::free_cmd_t              cmd,
  input  logic [$clog2(CAPACITY+1)-1:0]    entry,
  input  logic [$clog2(CAPACITY+1)-1:0]    link_rd,
  output logic [$clog2(CAPACITY+1)-1:0]    free_head
);
  import mssb_pkg::*;

  localparam int LW = $clog2(CAPACITY + 1);
  localparam logic [LW-1:0] LINK_NULL = LW'(CAPACITY);
  localparam logic [LW-1:0] LAST_ENTRY = LW'(CAPACITY - 1);

  // entries at or above the mark were never written, their link is implied
  logic [LW-1:0] mark;
  logic          fresh;
  logic [LW-1:0] fresh_next;

  assign fresh      = (free_head == mark);
  assign fresh_next = (free_head == LAST_ENTRY) ? LINK_NULL : free_head + LW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      free_head <= '0;
      mark      <= '0;
    end else if (cmd.take) begin
      if (fresh) begin
        free_head <= fresh_next;
        mark      <= free_head + LW'(1);
      end else begin
        free_head <= link_rd;
      end
    end else if (cmd.give) begin
      free_head <= entry;
    end
  end

endmodule

@@ rtl/mssb_checker.sv @@
// port-level checks for the multi-stack shared buffer and their bind
module mssb_checker #(
  parameter int VALUE_WIDTH = 32
) (
  input logic                                                  clk,
  input logic                                                  rst,
  input logic                                                  s_axis_tvalid,
  input logic                                                  s_axis_tready,
  input logic                                                  m_axis_tvalid,
  input logic                                                  m_axis_tready,
  input logic [((VALUE_WIDTH+mssb_pkg::STAT_W+1+7)/8)*8-1:0]    m_axis_tdata
);
  import mssb_pkg::*;

  localparam int VW = VALUE_WIDTH;
  localparam logic [VW-1:0] VAL_MIN = VW'(1) << (VW - 1);

  logic [VW-1:0]     o_value;
  logic [STAT_W-1:0] o_status;
  logic              o_empty;

  assign o_value  = m_axis_tdata[VW-1:0];
  assign o_status = m_axis_tdata[VW+STAT_W-1:VW];
  assign o_empty  = m_axis_tdata[VW+STAT_W];

  // a held result does not change
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // one beat at a time: after an accept the input side closes for the execute cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted during execute");

  // empty status carries the most negative value and the empty flag
  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && o_status == STAT_EMPTY |-> o_value == VAL_MIN && o_empty)
    else $error("empty result malformed");

  // bad index carries zero value and a clear empty flag
  a_bad_result: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && o_status == STAT_BAD_INDEX |-> o_value == '0 && !o_empty)
    else $error("bad index result malformed");

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind multi_stack_shared_buffer mssb_checker #(
  .VALUE_WIDTH (VALUE_WIDTH)
) u_mssb_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
